@@ src/qmc_pkg.sv @@
package qmc_pkg;

   // Queue geometry, id width and opcode width
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int OP_W        = 3;

   // Opcodes; codes five to seven act as a status query
   localparam logic [OP_W-1:0] OP_LOCK   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNLOCK = 3'd1;
   localparam logic [OP_W-1:0] OP_WAIT   = 3'd2;
   localparam logic [OP_W-1:0] OP_SIGNAL = 3'd3;
   localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [ID_W-1:0] requester_id;
   } cmd_type;

   typedef struct packed {
      logic             granted;
      logic             locked;
      logic             handoff_valid;
      logic [ID_W-1:0]  handoff_id;
      logic             signaled_valid;
      logic [ID_W-1:0]  signaled_id;
      logic             overflow;
      logic [CNT_W-1:0] waiting_count;
   } rsp_type;

   // Circular pointer advance
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

endpackage

@@ src/qmc_queue_ram.sv @@
module qmc_queue_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/qmc_lock_ctrl.sv @@
module qmc_lock_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            exec_en,
   input  qmc_pkg::cmd_type cmd,
   output qmc_pkg::rsp_type rsp
);

   logic                            held_ff, held_in;
   logic [qmc_pkg::ID_W-1:0]        owner_ff, owner_in;
   logic [qmc_pkg::PTR_W-1:0]       head_ff, head_in;
   logic [qmc_pkg::PTR_W-1:0]       tail_ff, tail_in;
   logic [qmc_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            pend_ff, pend_in;
   logic                            cvalid_ff, cvalid_in;
   logic [qmc_pkg::ID_W-1:0]        cthread_ff, cthread_in;

   logic                            wr_en;
   logic [qmc_pkg::ID_W-1:0]        head_word;
   logic                            is_owner;
   logic                            q_full;
   logic                            q_empty;

   // Head entry is read every cycle; head only moves on an execute edge and an
   // accept edge always separates two executes, so the word is always fresh.
   qmc_queue_ram #(
      .DEPTH (qmc_pkg::QUEUE_DEPTH),
      .WIDTH (qmc_pkg::ID_W)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (cmd.requester_id),
      .rd_addr (head_ff),
      .rd_data (head_word)
   );

   assign is_owner = held_ff && (owner_ff == cmd.requester_id);
   assign q_full   = (count_ff == qmc_pkg::CNT_W'(qmc_pkg::QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);

   // Operation decode and next state
   always_comb begin
      held_in    = held_ff;
      owner_in   = owner_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      cvalid_in  = cvalid_ff;
      cthread_in = cthread_ff;
      wr_en      = 1'b0;

      rsp.granted        = 1'b0;
      rsp.handoff_valid  = 1'b0;
      rsp.handoff_id     = '0;
      rsp.signaled_valid = 1'b0;
      rsp.signaled_id    = '0;
      rsp.overflow       = 1'b0;

      unique case (cmd.opcode)
         qmc_pkg::OP_LOCK: begin
            priority if (is_owner) begin
               // owner relock: no change
            end else if (!held_ff) begin
               held_in     = 1'b1;
               owner_in    = cmd.requester_id;
               rsp.granted = 1'b1;
            end else if (q_full) begin
               rsp.overflow = 1'b1;
            end else begin
               wr_en    = exec_en;
               tail_in  = qmc_pkg::next_slot(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         qmc_pkg::OP_UNLOCK, qmc_pkg::OP_WAIT: begin
            if (cmd.opcode == qmc_pkg::OP_WAIT) begin
               pend_in    = 1'b1;
               cvalid_in  = held_ff;
               cthread_in = held_ff ? owner_ff : '0;
            end
            // release (by the owner on unlock, by any requester on wait while held): hand to head waiter or free
            if ((cmd.opcode == qmc_pkg::OP_WAIT) ? held_ff : is_owner) begin
               if (!q_empty) begin
                  owner_in          = head_word;
                  head_in           = qmc_pkg::next_slot(head_ff);
                  count_in          = count_ff - 1'b1;
                  rsp.handoff_valid = 1'b1;
                  rsp.handoff_id    = head_word;
               end else begin
                  held_in  = 1'b0;
                  owner_in = '0;
               end
            end
         end
         qmc_pkg::OP_SIGNAL: begin
            if (pend_ff) begin
               rsp.signaled_valid = cvalid_ff;
               rsp.signaled_id    = cvalid_ff ? cthread_ff : '0;
               pend_in            = 1'b0;
               cvalid_in          = 1'b0;
               cthread_in         = '0;
            end
         end
         default: begin
            // status query
         end
      endcase

      rsp.locked        = held_in;
      rsp.waiting_count = count_in;
   end

   // Lock state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         owner_ff   <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         cvalid_ff  <= 1'b0;
         cthread_ff <= '0;
      end else if (exec_en) begin
         held_ff    <= held_in;
         owner_ff   <= owner_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         cvalid_ff  <= cvalid_in;
         cthread_ff <= cthread_in;
      end
   end

endmodule

@@ src/queued_mutex_with_condition_top.sv @@
// An accepted word is held in the command register; its result is registered into the output register on execute.
// A new word is accepted only once the previous one has executed; the queue head read is registered and the
// execute cycle reads, modifies and writes back the lock state and queue memory.
// Execute waits while a previous result is still held in the output register and not being taken.
// Reset (synchronous, active high) frees the mutex, empties the queue and clears
// the condition slot; the queue memory itself is not cleared.
module queued_mutex_with_condition_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [qmc_pkg::OP_W-1:0]   req_opcode,
   input  logic [qmc_pkg::ID_W-1:0]   req_requester_id,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_granted,
   output logic                       rsp_locked,
   output logic                       rsp_handoff_valid,
   output logic [qmc_pkg::ID_W-1:0]   rsp_handoff_id,
   output logic                       rsp_signaled_valid,
   output logic [qmc_pkg::ID_W-1:0]   rsp_signaled_id,
   output logic                       rsp_overflow,
   output logic [qmc_pkg::CNT_W-1:0]  rsp_waiting_count
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff, state_in;
   qmc_pkg::cmd_type  cmd_ff;
   qmc_pkg::rsp_type  rsp_next;
   qmc_pkg::rsp_type  rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_fire;
   logic              exec_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   qmc_lock_ctrl u_lock_ctrl (
      .clock   (clock),
      .reset   (reset),
      .exec_en (exec_fire),
      .cmd     (cmd_ff),
      .rsp     (rsp_next)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_EXEC;
         ST_EXEC: if (exec_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured word and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff.opcode       <= req_opcode;
         cmd_ff.requester_id <= req_requester_id;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_ff.granted;
   assign rsp_locked         = rsp_ff.locked;
   assign rsp_handoff_valid  = rsp_ff.handoff_valid;
   assign rsp_handoff_id     = rsp_ff.handoff_id;
   assign rsp_signaled_valid = rsp_ff.signaled_valid;
   assign rsp_signaled_id    = rsp_ff.signaled_id;
   assign rsp_overflow       = rsp_ff.overflow;
   assign rsp_waiting_count  = rsp_ff.waiting_count;

endmodule

@@ src/qmc_checker.sv @@
module qmc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_granted,
   input logic                       rsp_locked,
   input logic                       rsp_handoff_valid,
   input logic [qmc_pkg::ID_W-1:0]   rsp_handoff_id,
   input logic                       rsp_signaled_valid,
   input logic [qmc_pkg::ID_W-1:0]   rsp_signaled_id,
   input logic                       rsp_overflow,
   input logic [qmc_pkg::CNT_W-1:0]  rsp_waiting_count
);

   // A grant or a handoff always leaves the mutex held
   a_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_granted || rsp_handoff_valid) |-> rsp_locked)
      else $error("grant or handoff without lock held");

   // Overflow only with a full queue behind a held mutex
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_locked && (rsp_waiting_count == qmc_pkg::CNT_W'(qmc_pkg::QUEUE_DEPTH)))
      else $error("overflow with room in queue");

   // Ids are zero unless their valid flag is set
   a_ids_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_handoff_valid || rsp_handoff_id == '0) &&
                    (rsp_signaled_valid || rsp_signaled_id == '0))
      else $error("stray id on result");

   // Occupancy never exceeds the queue depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_waiting_count <= qmc_pkg::CNT_W'(qmc_pkg::QUEUE_DEPTH))
      else $error("waiting count beyond depth");

   // No result right after reset is released
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind queued_mutex_with_condition_top qmc_checker u_qmc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_granted        (rsp_granted),
   .rsp_locked         (rsp_locked),
   .rsp_handoff_valid  (rsp_handoff_valid),
   .rsp_handoff_id     (rsp_handoff_id),
   .rsp_signaled_valid (rsp_signaled_valid),
   .rsp_signaled_id    (rsp_signaled_id),
   .rsp_overflow       (rsp_overflow),
   .rsp_waiting_count  (rsp_waiting_count)
);
